/* hdl/kmcr_pkg.sv */
package kmcr_pkg;

    localparam int unsigned KEY_BITS  = 64;
    localparam int unsigned HALF_BITS = 32;

    // Event kinds carried on the result channel.
    localparam logic [1:0] KIND_PRESS           = 2'd0;
    localparam logic [1:0] KIND_RELEASE         = 2'd1;
    localparam logic [1:0] KIND_SPECIAL_PRESS   = 2'd2;
    localparam logic [1:0] KIND_SPECIAL_RELEASE = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SPECIAL_COUNT     = 2'd0;
    localparam logic [1:0] CFG_SPECIAL_PATTERN_A = 2'd1;
    localparam logic [1:0] CFG_SPECIAL_PATTERN_B = 2'd2;

    // At most 58 events leave per frame; this is the count of the final one.
    localparam logic [5:0] LAST_SLOT = 6'd57;

    typedef struct packed {
        logic load;   // capture a new frame and work out its events
        logic step;   // emit the next pending event into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic pending;    // events of the current frame still to emit
        logic slot_free;  // output register can take an event this cycle
    } t_dp_status;

    // Mask of keys that exist in a matrix of the given size.
    function automatic logic [KEY_BITS-1:0] geometry_mask(input int rows, input int cols);
        logic [KEY_BITS-1:0] m;
        m = '0;
        for (int c = 0; c < 8; c++) begin
            for (int r = 0; r < 8; r++) begin
                if (r < rows && c < cols) begin
                    m[c*8 + r] = 1'b1;
                end
            end
        end
        return m;
    endfunction

endpackage

/* hdl/kmcr_in_if.sv */
interface kmcr_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] pressed_keys;

    modport source (output valid, output pressed_keys, input ready);
    modport sink (input valid, input pressed_keys, output ready);
endinterface

/* hdl/kmcr_out_if.sv */
interface kmcr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [5:0] key_number;
    logic       last_event;

    modport source (output valid, output event_kind, output key_number, output last_event,
                    input ready);
    modport sink (input valid, input event_kind, input key_number, input last_event,
                  output ready);
endinterface

/* hdl/kmcr_ctrl.sv */
module kmcr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kmcr_pkg::t_dp_status i_status,
    output kmcr_pkg::t_dp_cmd   o_cmd
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_BUSY = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BUSY;
                end
            end
            S_BUSY: begin
                if (!i_status.pending) begin
                    n_state = S_IDLE;
                end else if (i_status.slot_free) begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/kmcr_datapath.sv */
module kmcr_datapath #(
    parameter logic [63:0] GEOM_MASK = 64'h00FF_FFFF_FFFF_FFFF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kmcr_pkg::t_dp_cmd    i_cmd,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic [63:0]          i_keys,
    input  logic                 i_out_ready,
    output kmcr_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    output logic [1:0]           o_event_kind,
    output logic [5:0]           o_key_number,
    output logic                 o_last_event
);

    // Configuration and frame-to-frame state.
    logic [1:0]  r_special_count;
    logic [63:0] r_pattern_a;
    logic [63:0] r_pattern_b;
    logic [63:0] r_prev_mask;
    logic [1:0]  r_latch;

    // Pending work of the frame in flight.
    logic [1:0]  r_sp_pend;
    logic [1:0]  r_sp_rel;
    logic [31:0] r_press_lo;
    logic [31:0] r_rel_lo;
    logic [31:0] r_press_hi;
    logic [31:0] r_rel_hi;
    logic [5:0]  r_cnt;

    // Output register.
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [5:0]  r_num;
    logic        r_last;

    // Frame evaluation.
    logic [63:0] mask;
    logic [1:0]  sp_en;
    logic [1:0]  sp_press;
    logic [1:0]  sp_rel;
    logic [1:0]  n_latch;
    logic        mask_zero;

    always_comb begin
        mask      = i_keys & GEOM_MASK;
        mask_zero = (mask == '0);
        sp_en[0]  = (r_special_count != 2'd0);
        sp_en[1]  = (r_special_count[1] == 1'b1);
        sp_press[0] = sp_en[0] && (mask == r_pattern_a) && !r_latch[0];
        sp_press[1] = sp_en[1] && (mask == r_pattern_b) && !r_latch[1];
        for (int i = 0; i < 2; i++) begin
            sp_rel[i]  = sp_en[i] && !sp_press[i] && r_latch[i] && mask_zero;
            n_latch[i] = sp_press[i] ? 1'b1 : (sp_rel[i] ? 1'b0 : r_latch[i]);
        end
    end

    // Selection of the next event.
    logic [31:0] vec;
    logic [31:0] lowbit;
    logic [4:0]  low_idx;
    logic        sel_hi;
    logic [1:0]  sel_kind;
    logic [5:0]  sel_num;
    logic [1:0]  n_sp_pend;
    logic [31:0] n_press_lo;
    logic [31:0] n_rel_lo;
    logic [31:0] n_press_hi;
    logic [31:0] n_rel_hi;
    logic        any_after;
    logic        is_last;

    always_comb begin
        vec      = '0;
        sel_hi   = 1'b0;
        sel_kind = kmcr_pkg::KIND_PRESS;
        if (r_press_lo != '0) begin
            vec = r_press_lo;
        end else if (r_rel_lo != '0) begin
            vec      = r_rel_lo;
            sel_kind = kmcr_pkg::KIND_RELEASE;
        end else if (r_press_hi != '0) begin
            vec    = r_press_hi;
            sel_hi = 1'b1;
        end else begin
            vec      = r_rel_hi;
            sel_hi   = 1'b1;
            sel_kind = kmcr_pkg::KIND_RELEASE;
        end
        lowbit  = vec & (~vec + 32'd1);
        low_idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (lowbit[i]) begin
                low_idx = low_idx | 5'(i);
            end
        end

        n_sp_pend  = r_sp_pend;
        n_press_lo = r_press_lo;
        n_rel_lo   = r_rel_lo;
        n_press_hi = r_press_hi;
        n_rel_hi   = r_rel_hi;
        priority if (r_sp_pend[0]) begin
            sel_kind     = r_sp_rel[0] ? kmcr_pkg::KIND_SPECIAL_RELEASE
                                       : kmcr_pkg::KIND_SPECIAL_PRESS;
            sel_num      = 6'd0;
            n_sp_pend[0] = 1'b0;
        end else if (r_sp_pend[1]) begin
            sel_kind     = r_sp_rel[1] ? kmcr_pkg::KIND_SPECIAL_RELEASE
                                       : kmcr_pkg::KIND_SPECIAL_PRESS;
            sel_num      = 6'd1;
            n_sp_pend[1] = 1'b0;
        end else begin
            sel_num = {sel_hi, low_idx};
            if (r_press_lo != '0) begin
                n_press_lo = r_press_lo & ~lowbit;
            end else if (r_rel_lo != '0) begin
                n_rel_lo = r_rel_lo & ~lowbit;
            end else if (r_press_hi != '0) begin
                n_press_hi = r_press_hi & ~lowbit;
            end else begin
                n_rel_hi = r_rel_hi & ~lowbit;
            end
        end
        any_after = (n_sp_pend != '0) || (n_press_lo != '0) || (n_rel_lo != '0)
                    || (n_press_hi != '0) || (n_rel_hi != '0);
        is_last   = !any_after || (r_cnt == kmcr_pkg::LAST_SLOT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_special_count <= '0;
            r_pattern_a     <= '0;
            r_pattern_b     <= '0;
            r_prev_mask     <= '0;
            r_latch         <= '0;
            r_sp_pend       <= '0;
            r_press_lo      <= '0;
            r_rel_lo        <= '0;
            r_press_hi      <= '0;
            r_rel_hi        <= '0;
            r_cnt           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    kmcr_pkg::CFG_SPECIAL_COUNT:     r_special_count <= i_cfg_data[1:0];
                    kmcr_pkg::CFG_SPECIAL_PATTERN_A: r_pattern_a     <= i_cfg_data;
                    kmcr_pkg::CFG_SPECIAL_PATTERN_B: r_pattern_b     <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                r_prev_mask <= mask;
                r_latch     <= n_latch;
                r_sp_pend   <= sp_press | sp_rel;
                r_press_lo  <= mask[31:0] & ~r_prev_mask[31:0];
                r_rel_lo    <= r_prev_mask[31:0] & ~mask[31:0];
                r_press_hi  <= mask[63:32] & ~r_prev_mask[63:32];
                r_rel_hi    <= r_prev_mask[63:32] & ~mask[63:32];
                r_cnt       <= '0;
            end else if (i_cmd.step) begin
                // The final event of a frame retires all remaining work.
                r_sp_pend  <= is_last ? '0 : n_sp_pend;
                r_press_lo <= is_last ? '0 : n_press_lo;
                r_rel_lo   <= is_last ? '0 : n_rel_lo;
                r_press_hi <= is_last ? '0 : n_press_hi;
                r_rel_hi   <= is_last ? '0 : n_rel_hi;
                r_cnt      <= r_cnt + 6'd1;
            end

            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Special release flags ride along with the pending bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sp_rel <= sp_rel;
        end
        if (i_cmd.step) begin
            r_kind <= sel_kind;
            r_num  <= sel_num;
            r_last <= is_last;
        end
    end

    assign o_status.pending   = (r_sp_pend != '0) || (r_press_lo != '0) || (r_rel_lo != '0)
                                || (r_press_hi != '0) || (r_rel_hi != '0);
    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_key_number = r_num;
    assign o_last_event = r_last;

endmodule

/* hdl/keypad_matrix_change_reporter_unit.sv */
// Keypad matrix change reporter.
//
// The input channel carries one beat per complete scan frame: a 64-bit mask with bit
// column*8+row set for each pressed key. Keys outside the ROWS by COLUMNS geometry are
// ignored. The output channel carries one beat per event: special chord presses and
// releases first, then ordinary presses and releases of the low 32 keys, then of the
// high 32 keys, each group in ascending key order. The final beat of a frame has
// last_event set; a frame that changes nothing produces no beat at all.
//
// The frame is captured into the pending change vectors, and its first event is then
// moved into the output register. The frame's events then leave at one per cycle while
// the receiver keeps taking them, chosen by a lowest-set-bit search over the pending
// change vectors. The input is ready again once the last event has entered the output
// register and the controller has gone back to idle, even if the receiver has not
// taken it.
//
// Reset clears the previous frame, the special key latches and all configuration
// registers. When the receiver stalls, the output register holds its beat and the
// event search pauses; nothing is dropped. Configuration writes go through the plain
// write port and must only be issued while the block is idle.
module keypad_matrix_change_reporter_unit #(
    parameter int ROWS    = 8,
    parameter int COLUMNS = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kmcr_in_if.sink           i_in_ch,
    kmcr_out_if.source        o_out_ch,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data
);

    // Keys that exist in this matrix; everything else is masked off at capture.
    localparam logic [63:0] GEOM_MASK = kmcr_pkg::geometry_mask(ROWS, COLUMNS);

    kmcr_pkg::t_dp_cmd    dp_cmd;
    kmcr_pkg::t_dp_status dp_status;

    // The controller sequences capture and event emission.
    kmcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (i_in_ch.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the state, the pending change vectors and the output register.
    kmcr_datapath #(
        .GEOM_MASK (GEOM_MASK)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_keys       (i_in_ch.pressed_keys),
        .i_out_ready  (o_out_ch.ready),
        .o_status     (dp_status),
        .o_out_valid  (o_out_ch.valid),
        .o_event_kind (o_out_ch.event_kind),
        .o_key_number (o_out_ch.key_number),
        .o_last_event (o_out_ch.last_event)
    );

endmodule

/* hdl/kmcr_checker.sv */
module kmcr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_event_kind,
    input logic [5:0] i_key_number,
    input logic       i_last_event
);

    // A held beat keeps its payload until taken.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
        i_out_valid && $stable(i_event_kind) && $stable(i_key_number) && $stable(i_last_event))
        else $error("output beat changed while stalled");

    // A frame just taken keeps the input closed for the next cycle.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a frame was taken");

    // While a frame still has events after this one, no new frame is taken.
    a_no_in_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_event |-> !i_in_ready)
        else $error("input ready before the last event of a frame");

    // Nothing is shown on the output right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind keypad_matrix_change_reporter_unit kmcr_checker u_kmcr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_ch.valid),
    .i_in_ready   (i_in_ch.ready),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_event_kind (o_out_ch.event_kind),
    .i_key_number (o_out_ch.key_number),
    .i_last_event (o_out_ch.last_event)
);

/* sim/tb_keypad_matrix_change_reporter_unit.sv */
`timescale 1ns / 100ps

module tb_keypad_matrix_change_reporter_unit;

    localparam int ROWS    = 8;
    localparam int COLUMNS = 7;

    // A frame never produces more events than this; any further events are dropped.
    localparam int MAX_FRAME_EVENTS = int'(kmcr_pkg::LAST_SLOT) + 1;

    // No register lives at this index, so a write to it must change nothing.
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    // Cycles with no beat on either channel before the run is declared hung. The
    // longest quiet stretch is the deliberate output stall.
    localparam int WATCHDOG_LIMIT = 2000;

    // After the last expected event has arrived, a frame that changes nothing may
    // still be in flight.
    localparam int SETTLE_CYCLES = 8;

    // The drain at the end covers the longest frame the block can be busy with.
    localparam int FINAL_DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] key;
        logic       last;
    } t_key_event;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    kmcr_in_if  in_ch();
    kmcr_out_if out_ch();

    keypad_matrix_change_reporter_unit #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Our own copy of the block's state and configuration.
    logic [63:0] live_keys;
    logic [63:0] seen_mask;
    logic [1:0]  chord_latch;
    logic [1:0]  chord_count;
    logic [63:0] chord_pattern_a;
    logic [63:0] chord_pattern_b;

    // Events of the frame being predicted, then the store of events still owed by the block.
    t_key_event frame_events[$];
    t_key_event owed_events[$];

    // Shared run controls and statistics.
    bit          idle_on;
    int          hold_request;
    int          failures;
    int          frames_sent;
    int          events_checked;
    int          settings_used;
    logic [63:0] last_frame;

    // ------------------------------------------------------------------------
    // Event prediction
    // ------------------------------------------------------------------------

    // Keys that exist in the configured matrix: ROWS bits in each of COLUMNS columns.
    function automatic logic [63:0] matrix_keys();
        logic [63:0] keys;
        logic [7:0]  row_bits;
        keys = '0;
        row_bits = 8'((1 << ROWS) - 1);
        for (int c = 0; c < COLUMNS; c++) begin
            keys[c*8 +: 8] = row_bits;
        end
        return keys;
    endfunction

    function automatic void note_event(input logic [1:0] kind, input int key);
        t_key_event ev;
        ev.kind = kind;
        ev.key  = key[5:0];
        ev.last = 1'b0;
        if (frame_events.size() < MAX_FRAME_EVENTS) begin
            frame_events.push_back(ev);
        end
    endfunction

    // Works out every event one scan frame causes and adds them to the owed store.
    // Special chords come first, then presses and releases of the low half, then the
    // high half, each in ascending key order. The state is updated in full even if
    // events had to be dropped.
    task automatic predict_frame(input logic [63:0] raw);
        logic [63:0] scan;
        logic [63:0] pattern;
        logic [31:0] now_half;
        logic [31:0] prev_half;
        logic [31:0] went_down;
        logic [31:0] went_up;
        t_key_event  ev;
        int          chords;
        scan = raw & live_keys;
        chords = (chord_count > 2'd2) ? 2 : int'(chord_count);
        frame_events.delete();
        for (int i = 0; i < chords; i++) begin
            pattern = (i == 0) ? chord_pattern_a : chord_pattern_b;
            if (scan == pattern && !chord_latch[i]) begin
                note_event(kmcr_pkg::KIND_SPECIAL_PRESS, i);
                chord_latch[i] = 1'b1;
            end else if (chord_latch[i] && scan == '0) begin
                note_event(kmcr_pkg::KIND_SPECIAL_RELEASE, i);
                chord_latch[i] = 1'b0;
            end
        end
        for (int h = 0; h < 2; h++) begin
            now_half  = scan[h*kmcr_pkg::HALF_BITS +: kmcr_pkg::HALF_BITS];
            prev_half = seen_mask[h*kmcr_pkg::HALF_BITS +: kmcr_pkg::HALF_BITS];
            went_down = now_half & ~prev_half;
            went_up   = prev_half & ~now_half;
            for (int b = 0; b < kmcr_pkg::HALF_BITS; b++) begin
                if (went_down[b]) note_event(kmcr_pkg::KIND_PRESS, h*kmcr_pkg::HALF_BITS + b);
            end
            for (int b = 0; b < kmcr_pkg::HALF_BITS; b++) begin
                if (went_up[b]) note_event(kmcr_pkg::KIND_RELEASE, h*kmcr_pkg::HALF_BITS + b);
            end
        end
        seen_mask = scan;
        for (int j = 0; j < frame_events.size(); j++) begin
            ev = frame_events[j];
            ev.last = (j == frame_events.size() - 1);
            owed_events.push_back(ev);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int random_key_index();
        return $urandom_range(0, COLUMNS - 1) * 8 + $urandom_range(0, ROWS - 1);
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // A small chord of up to three keys that exist in the matrix; two or three keys are drawn, and a draw may repeat.
    function automatic logic [63:0] random_chord();
        logic [63:0] chord;
        int          keys;
        chord = '0;
        keys = $urandom_range(2, 3);
        for (int k = 0; k < keys; k++) begin
            chord[random_key_index()] = 1'b1;
        end
        return chord;
    endfunction

    // Pattern choices for a chord register: all released, a real chord, a word that
    // almost surely has keys outside the matrix, or the whole matrix.
    function automatic logic [63:0] random_pattern();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return random_chord();
            2: return random_word();
            default: return live_keys;
        endcase
    endfunction

    // Sends one scan frame. The input may stay valid straight into the next frame,
    // so valid is only lowered when an idle gap is drawn.
    task automatic send_frame(input logic [63:0] frame);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.pressed_keys <= frame;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_frame(frame);
        last_frame = frame;
        frames_sent++;
    endtask

    // Stops the sender and waits until every owed event has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (owed_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes every register in turn, plus the unused index, which the block must ignore.
    // The block has to be idle when this is called.
    task automatic set_specials(input logic [1:0] count, input logic [63:0] pattern_a,
                                input logic [63:0] pattern_b);
        cfg_we    <= 1'b1;
        cfg_index <= kmcr_pkg::CFG_SPECIAL_COUNT;
        cfg_data  <= {62'(random_word()), count};
        @(posedge i_clk);
        cfg_index <= kmcr_pkg::CFG_SPECIAL_PATTERN_A;
        cfg_data  <= pattern_a;
        @(posedge i_clk);
        cfg_index <= kmcr_pkg::CFG_SPECIAL_PATTERN_B;
        cfg_data  <= pattern_b;
        @(posedge i_clk);
        cfg_index <= CFG_UNUSED_INDEX;
        cfg_data  <= random_word();
        @(posedge i_clk);
        cfg_we <= 1'b0;
        chord_count     = count;
        chord_pattern_a = pattern_a;
        chord_pattern_b = pattern_b;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Ordinary keys with no chords configured: the corner keys, the boundary between
    // the two halves, a full matrix, keys that do not exist, and an unchanged frame.
    task automatic test_plain_keys();
        send_frame(64'h0000_0000_0000_0001);
        send_frame(64'h0080_0000_0000_0000);
        send_frame(64'h0000_0001_8000_0000);
        send_frame('1);
        send_frame(64'hFF00_0000_0000_0000);
        send_frame(64'hFF00_0000_0000_0000);
        send_frame(64'h0000_0000_0000_0000);
        wait_drained();
    endtask

    // Chord keys: an all-released pattern presses on an empty frame and releases on
    // the next one, a real chord presses once while held, and its keys also produce
    // ordinary events.
    task automatic test_special_chords();
        logic [63:0] chord;
        chord = 64'h0000_0100_0010_0008;
        set_specials(2'd2, chord, '0);
        send_frame('0);
        send_frame('0);
        send_frame(chord);
        send_frame(chord);
        send_frame(chord | 64'h20);
        send_frame('0);
        send_frame('0);
        wait_drained();
    endtask

    // Register extremes: a count of three acts as two, a pattern with keys outside the
    // matrix never fires, and two full-matrix chords give the largest possible frame.
    task automatic test_config_extremes();
        set_specials(2'd3, '1, live_keys);
        send_frame('1);
        send_frame('0);
        wait_drained();
        set_specials(2'd2, live_keys, live_keys);
        send_frame(live_keys);
        send_frame('0);
        wait_drained();
        set_specials(2'd0, random_chord(), '0);
        send_frame('1);
        send_frame('0);
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while dense frames keep coming, so the
    // block fills its output and has to stall its input.
    task automatic test_backpressure();
        hold_request = 300;
        for (int k = 0; k < 8; k++) begin
            send_frame((k % 2 == 0) ? (random_word() & live_keys) : 64'h0);
        end
        wait_drained();
    endtask

    // Random frames in several configuration phases. Most frames look like real
    // keypad activity: a few keys change, chords are pressed and let go. The rest is
    // noise, keys outside the matrix and repeated frames.
    task automatic test_random_frames();
        logic [63:0] frame;
        int          toggles;
        for (int phase = 0; phase < 5; phase++) begin
            set_specials($urandom_range(0, 3), random_pattern(), random_pattern());
            idle_on = (phase != 2);
            for (int n = 0; n < 24; n++) begin
                frame = last_frame;
                case ($urandom_range(0, 11))
                    0, 1, 2, 3, 4: begin
                        toggles = $urandom_range(1, 3);
                        for (int t = 0; t < toggles; t++) begin
                            frame[random_key_index()] ^= 1'b1;
                        end
                    end
                    5, 6: frame = $urandom_range(0, 1) ? chord_pattern_a : chord_pattern_b;
                    7: frame = '0;
                    8: frame = random_word();
                    9: frame = random_chord();
                    10: frame = last_frame;
                    default: frame = $urandom_range(0, 1) ? live_keys
                                                          : (random_word() & ~live_keys);
                endcase
                send_frame(frame);
            end
            // The sender pauses here until everything owed has come out.
            wait_drained();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready with random stalls, and the event checker
    // ------------------------------------------------------------------------

    // Each accepted beat draws a random stall while idle gaps are on. A long hold
    // requested by a test is counted down here.
    initial begin : event_sink
        int gap_left;
        int hold_left;
        gap_left  = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (out_ch.valid && out_ch.ready) begin
                gap_left = idle_on ? $urandom_range(0, 4) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Every beat on the result channel is matched against the oldest owed event.
    always @(posedge i_clk) begin : event_check
        t_key_event want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (owed_events.size() == 0) begin
                $display("%0t: unexpected event kind %0d key %0d last %0d", $time,
                         out_ch.event_kind, out_ch.key_number, out_ch.last_event);
                failures++;
            end else begin
                want = owed_events.pop_front();
                if (out_ch.event_kind !== want.kind) begin
                    $display("%0t: event_kind expected %0d actual %0d", $time,
                             want.kind, out_ch.event_kind);
                    failures++;
                end
                if (out_ch.key_number !== want.key) begin
                    $display("%0t: key_number expected %0d actual %0d", $time,
                             want.key, out_ch.key_number);
                    failures++;
                end
                if (out_ch.last_event !== want.last) begin
                    $display("%0t: last_event expected %0d actual %0d", $time,
                             want.last, out_ch.last_event);
                    failures++;
                end
            end
            events_checked++;
        end
    end

    // A hung block shows up as a long run of cycles with no beat on either channel.
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d events still owed", $time,
                     quiet_cycles, owed_events.size());
            $display("keypad_matrix_change_reporter_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        live_keys       = matrix_keys();
        seen_mask       = '0;
        chord_latch     = '0;
        chord_count     = '0;
        chord_pattern_a = '0;
        chord_pattern_b = '0;
        last_frame      = '0;
        idle_on         = 1'b1;
        hold_request    = 0;
        failures        = 0;
        frames_sent     = 0;
        events_checked  = 0;
        settings_used   = 0;

        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.pressed_keys <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= kmcr_pkg::CFG_SPECIAL_COUNT;
        cfg_data           <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_keys();
        test_special_chords();
        test_config_extremes();
        test_backpressure();
        test_random_frames();

        wait_drained();
        repeat (FINAL_DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d scan frames and %0d events under %0d chord settings,",
                 frames_sent, events_checked, settings_used);
        $display("including full-matrix frames, off-matrix keys and a long output stall.");
        if (failures == 0 && owed_events.size() == 0) begin
            $display("keypad_matrix_change_reporter_unit: match");
        end else begin
            $display("%0d failures, %0d events never arrived", failures,
                     owed_events.size());
            $display("keypad_matrix_change_reporter_unit: mismatch");
        end
        $finish;
    end

endmodule

/* keypad_matrix_change_reporter_unit.f */
hdl/kmcr_pkg.sv
hdl/kmcr_in_if.sv
hdl/kmcr_out_if.sv
hdl/kmcr_ctrl.sv
hdl/kmcr_datapath.sv
hdl/keypad_matrix_change_reporter_unit.sv
hdl/kmcr_checker.sv
sim/tb_keypad_matrix_change_reporter_unit.sv
